FILE: hdl/salc_pkg.sv
package salc_pkg;

  localparam int MAX_INDEX_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF       = 8;
  localparam int ADDR_WIDTH_DEF     = 32;

  localparam int CNT_W = 32;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;
  localparam logic [1:0] KIND_IFETCH = 2'd3;

  localparam logic [1:0] OUT_HIT    = 2'd0;
  localparam logic [1:0] OUT_FILL   = 2'd1;
  localparam logic [1:0] OUT_EVICT  = 2'd2;
  localparam logic [1:0] OUT_NONE   = 2'd3;

  localparam logic [1:0] REG_INDEX_BITS  = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;  // capture input item
    logic rd_set;     // issue set read
    logic update;     // compare read data and write back the set
    logic clr_valid;  // clear the valid row of one set
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_modify;
    logic is_ifetch;
    logic clr_last;   // the clearing pass is at its last set
  } dp_sts_t;

endpackage

FILE: hdl/salc_ctrl.sv
module salc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  salc_pkg::dp_sts_t sts,
  output salc_pkg::dp_cmd_t cmd,
  output logic              first_acc,
  output logic              res_load
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_UPD, S_READ2, S_UPD2} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Input is taken only when the result slot is free or being drained now.
  logic slot_free;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    first_acc     = 1'b1;
    res_load      = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_valid = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        if (sts.is_ifetch) begin
          if (slot_free) begin
            res_load      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.rd_set = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (sts.is_modify) begin
          state_nxt = S_READ2;
        end else begin
          state_nxt = S_IDLE;
          res_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      S_READ2: begin
        first_acc  = 1'b0;
        cmd.rd_set = 1'b1;
        state_nxt  = S_UPD2;
      end
      S_UPD2: begin
        first_acc     = 1'b0;
        cmd.update    = 1'b1;
        res_load      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The slot is free whenever an item is taken, so a result never overwrites one.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> slot_free) else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD2) |-> $past(state_r == S_READ2)) else $error("bad second access");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> $past(cmd.rd_set)) else $error("update without read");

endmodule

FILE: hdl/salc_dp.sv
module salc_dp #(
  parameter int MAX_INDEX_BITS = salc_pkg::MAX_INDEX_BITS_DEF,
  parameter int MAX_WAYS       = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH     = salc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  salc_pkg::dp_cmd_t   cmd,
  output salc_pkg::dp_sts_t   sts,
  input  logic                first_acc,
  input  logic                res_load,
  input  logic                out_ready,
  input  logic                out_valid,
  input  salc_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output salc_pkg::out_item_t out_item
);

  localparam int SETS  = 1 << MAX_INDEX_BITS;
  localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int SH_W   = 7;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
  localparam int CW = salc_pkg::CNT_W;

  typedef logic [ADDR_WIDTH-1:0] tag_t;
  typedef logic [RANK_W-1:0]     rank_t;

  // Config registers.
  logic [2:0] index_bits_r;
  logic [4:0] offset_bits_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r  <= 3'd4;
      offset_bits_r <= 5'd4;
      ways_r        <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        salc_pkg::REG_INDEX_BITS:  index_bits_r  <= cfg_data[2:0];
        salc_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_data[4:0];
        salc_pkg::REG_WAYS:        ways_r        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Item and derived address fields, registered at capture.
  logic [1:0]       kind_r;
  logic [SET_W-1:0] set_r;
  tag_t             tag_r;
  logic [WCNT_W-1:0] nways_r;

  logic [SH_W-1:0]   ib, tsh;
  logic [ADDR_WIDTH-1:0] addr_ext, set_full;
  logic [WCNT_W-1:0] nways_c;

  always_comb begin
    ib = (SH_W'(index_bits_r) > SH_W'(MAX_INDEX_BITS)) ? SH_W'(MAX_INDEX_BITS)
                                                      : SH_W'(index_bits_r);
    tsh = SH_W'(offset_bits_r) + ib;
    addr_ext = ADDR_WIDTH'(in_item.address);
    set_full = (addr_ext >> offset_bits_r) & ~({ADDR_WIDTH{1'b1}} << ib);
    if (ways_r == 4'd0)                    nways_c = WCNT_W'(1);
    else if (32'(ways_r) > MAX_WAYS)       nways_c = WCNT_W'(MAX_WAYS);
    else                                   nways_c = WCNT_W'(ways_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r  <= in_item.kind;
      set_r   <= SET_W'(set_full);
      tag_r   <= (32'(tsh) >= ADDR_WIDTH) ? '0 : (addr_ext >> tsh);
      nways_r <= nways_c;
    end
  end

  // Clearing pass after reset: one valid row per cycle.
  logic [SET_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_valid) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.is_modify = (kind_r == salc_pkg::KIND_MODIFY);
  assign sts.is_ifetch = (kind_r == salc_pkg::KIND_IFETCH);
  assign sts.clr_last  = (clr_addr_r == SET_W'(SETS - 1));

  // Set memories: one row per set holds all ways.
  tag_t  tag_mem  [SETS][MAX_WAYS];
  rank_t rank_mem [SETS][MAX_WAYS];
  logic [MAX_WAYS-1:0] valid_mem [SETS];

  tag_t  rd_tag  [MAX_WAYS];
  rank_t rd_rank [MAX_WAYS];
  logic [MAX_WAYS-1:0] rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.rd_set) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        rd_tag[w]  <= tag_mem[set_r][w];
        rd_rank[w] <= rank_mem[set_r][w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid <= '0;
    end else if (cmd.rd_set) begin
      rd_valid <= valid_mem[set_r];
    end
  end

  // Compare and next-row computation.
  logic [MAX_WAYS-1:0] act, hit_vec, inv_vec;
  logic                hit;
  logic [WAY_W-1:0]    hit_way, inv_way, vic_way, sel_way;
  logic                any_inv;
  rank_t               lim, vic_rank;
  logic [1:0]          res;
  rank_t               new_rank [MAX_WAYS];

  always_comb begin
    hit = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
    vic_way = '0; vic_rank = rd_rank[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      act[w]     = (w < 32'(nways_r));
      hit_vec[w] = act[w] && rd_valid[w] && (rd_tag[w] == tag_r);
      inv_vec[w] = act[w] && !rd_valid[w];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin hit = 1'b1; hit_way = WAY_W'(w); end
      if (inv_vec[w]) begin any_inv = 1'b1; inv_way = WAY_W'(w); end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (act[w] && rd_rank[w] > vic_rank) begin
        vic_rank = rd_rank[w]; vic_way = WAY_W'(w);
      end
    end
    if (hit) begin
      sel_way = hit_way; lim = rd_rank[hit_way]; res = salc_pkg::OUT_HIT;
    end else if (any_inv) begin
      sel_way = inv_way; lim = RANK_MAX; res = salc_pkg::OUT_FILL;
    end else begin
      sel_way = vic_way; lim = RANK_MAX; res = salc_pkg::OUT_EVICT;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_rank[w] = rd_rank[w];
      if (WAY_W'(w) == sel_way) begin
        new_rank[w] = '0;
      end else if (act[w] && rd_valid[w] && rd_rank[w] < lim && rd_rank[w] < RANK_MAX) begin
        new_rank[w] = rd_rank[w] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        rank_mem[set_r][w] <= new_rank[w];
      end
      if (res != salc_pkg::OUT_HIT) tag_mem[set_r][sel_way] <= tag_r;
    end
  end

  // A fill writes back the row it read with the new way marked valid.
  always_ff @(posedge clk) begin
    if (cmd.clr_valid) begin
      valid_mem[clr_addr_r] <= '0;
    end else if (cmd.update && res == salc_pkg::OUT_FILL) begin
      valid_mem[set_r] <= rd_valid | (MAX_WAYS'(1) << sel_way);
    end
  end

  // Counters and result register.
  logic [CW-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [1:0]    outcome_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.update) begin
      if (res == salc_pkg::OUT_HIT) begin
        if (hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + 1'b1;
      end else begin
        if (miss_cnt_r != '1) miss_cnt_r <= miss_cnt_r + 1'b1;
        if (res == salc_pkg::OUT_EVICT && evict_cnt_r != '1)
          evict_cnt_r <= evict_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && first_acc) outcome_r <= res;
  end

  // Result register; holds the payload while out_valid waits.
  salc_pkg::out_item_t out_r;
  logic                ext_hit;
  always_comb ext_hit = cmd.update && res == salc_pkg::OUT_HIT;

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (sts.is_ifetch) begin
        out_r.outcome   <= salc_pkg::OUT_NONE;
        out_r.extra_hit <= 1'b0;
      end else begin
        out_r.outcome   <= first_acc ? res : outcome_r;
        out_r.extra_hit <= !first_acc;
      end
      out_r.hit_total   <= (ext_hit && hit_cnt_r != '1) ? hit_cnt_r + 1'b1 : hit_cnt_r;
      out_r.miss_total  <= (cmd.update && !ext_hit && miss_cnt_r != '1)
                           ? miss_cnt_r + 1'b1 : miss_cnt_r;
      out_r.evict_total <= (cmd.update && res == salc_pkg::OUT_EVICT && evict_cnt_r != '1)
                           ? evict_cnt_r + 1'b1 : evict_cnt_r;
    end
  end
  assign out_item = out_r;

  // The second access of a modify always hits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !first_acc) |-> hit) else $error("second access missed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_r)) else $error("result changed");
  // An eviction happens only when every active way of the set is valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !hit && !any_inv) |-> ((rd_valid | ~act) == '1))
    else $error("eviction with a free way");

endmodule

FILE: hdl/set_assoc_lru_cache_model_core.sv
// Set-associative LRU cache model core.
// Sequence: a fetch is answered without a set access; a load or store makes one access and a
// modify two; each access reads the set row, then compares and writes the row back.
// A new item is taken only after the previous one has finished and the result slot is free.
// Reset (rst_n low, synchronous): counters and config registers return to defaults; then a
// clearing pass over every set (64 by default) empties the valid bits with in_ready low.
module set_assoc_lru_cache_model_core #(
  parameter int MAX_INDEX_BITS = salc_pkg::MAX_INDEX_BITS_DEF,
  parameter int MAX_WAYS       = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH     = salc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  salc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output salc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  salc_pkg::dp_cmd_t cmd;
  salc_pkg::dp_sts_t sts;
  logic              first_acc;
  logic              res_load;

  // Config writes are taken unchecked; the user must send them only while the block is idle.
  assign cfg_ready = 1'b1;

  // The controller sequences the clearing pass and the read and the write of each access.
  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .first_acc (first_acc),
    .res_load  (res_load)
  );

  // The datapath holds the set memories, the counters and the result register.
  salc_dp #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .MAX_WAYS       (MAX_WAYS),
    .ADDR_WIDTH     (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .first_acc (first_acc),
    .res_load  (res_load),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .in_item   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_data)
  );

endmodule
